// File: rtl/core/ssd_drv_pkg.sv
package ssd_drv_pkg;

	// default digit count of the display
	localparam int DIGIT_COUNT_DEF = 4;

	// field and register widths
	localparam int NUMBER_W   = 16;
	localparam int SYM_W      = 4;
	localparam int PH_W       = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	// request codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ENABLE = 1'd1;

	localparam logic [2:0] BRIGHTNESS_RST = 3'd7;
	localparam logic       ENABLE_RST     = 1'b1;

	// frame command bytes
	localparam logic [7:0] CMD_DATA      = 8'h40;
	localparam logic [7:0] CMD_ADDR      = 8'hC0;
	localparam logic [7:0] CMD_CTRL_BASE = 8'h80;

	// element lengths in phases
	localparam logic [PH_W-1:0] START_LEN = 5'd3;
	localparam logic [PH_W-1:0] STOP_LEN  = 5'd4;
	localparam logic [PH_W-1:0] BYTE_LEN  = 5'd28;

	// byte element phases past the eight data bits (ack slot)
	localparam logic [PH_W-1:0] PH_ACK_CLK_LOW = 5'd24;
	localparam logic [PH_W-1:0] PH_ACK_RELEASE = 5'd25;
	localparam logic [PH_W-1:0] PH_ACK_CLK_HIGH = 5'd26;

	// x / 10 == (x * 0xCCCD) >> 19 for any 16-bit x
	localparam logic [15:0] DIV10_MULT  = 16'hCCCD;
	localparam int          DIV10_SHIFT = 19;

	typedef enum logic [1:0] {
		ELEM_START,
		ELEM_BYTE,
		ELEM_STOP
	} elem_kind_t;

	typedef struct packed {
		logic                func;
		logic [NUMBER_W-1:0] number;
	} in_item_t;

	typedef struct packed {
		logic clock_line;
		logic data_line;
		logic data_drive;
		logic busy_res;
		logic frame_done;
	} out_item_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0:    code = 8'h3F;
			4'd1:    code = 8'h06;
			4'd2:    code = 8'h5B;
			4'd3:    code = 8'h4F;
			4'd4:    code = 8'h66;
			4'd5:    code = 8'h6D;
			4'd6:    code = 8'h7D;
			4'd7:    code = 8'h07;
			4'd8:    code = 8'h7F;
			4'd9:    code = 8'h6F;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/core/ssd_drv_conv.sv
// Binary to segment-code converter: one decimal digit per cycle, least
// significant first. Digits past the last one are dropped, which is the
// reduction modulo 10^DIGIT_COUNT.
module ssd_drv_conv #(
	parameter int DIGIT_COUNT = ssd_drv_pkg::DIGIT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ssd_drv_pkg::NUMBER_W-1:0]    number,
	output logic [DIGIT_COUNT-1:0][7:0]         seg_codes
);

	localparam int CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int NW    = ssd_drv_pkg::NUMBER_W;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    n_q;
	logic [DIGIT_COUNT-1:0][7:0] seg_q;

	logic [2*NW-1:0]  prod;
	logic [NW-1:0]    quot;
	logic [NW-1:0]    quot_x10;
	logic [NW-1:0]    rem_full;
	logic [3:0]       digit;

	assign prod     = n_q * ssd_drv_pkg::DIV10_MULT;
	assign quot     = NW'(prod >> ssd_drv_pkg::DIV10_SHIFT);
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem_full = n_q - quot_x10;
	assign digit    = rem_full[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			seg_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				if (cnt_q == CNT_W'(DIGIT_COUNT - 1 - i))
					seg_q[i] <= ssd_drv_pkg::seg_code(digit);
			end
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIGIT_COUNT - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			n_q <= number;
		else if (busy_q)
			n_q <= quot;
	end

	assign seg_codes = seg_q;

endmodule

// File: rtl/core/seven_segment_two_wire_display_driver_top.sv
// Channel | Dir | Handshake         | Payload
// --------+-----+-------------------+-----------------------------------------
// in      | in  | in_valid/in_stall | in_data  : func, number
// out     | out | out_valid/out_stall | out_data : clock, data, drive, busy, done
// cfg     | in  | cfg_we            | cfg_index, cfg_wdata (no read-back)
//
// Each accepted request updates the line state and lands in the result
// register on the same edge; one request per cycle while in_stall is low.
// The binary-to-segment conversion after a load runs in the background and
// is done long before the first segment byte goes out.
// arst_n clears the sequencer to idle with clock and data high and driven.
// in_stall is high only while a result is held and out_stall is high.
module seven_segment_two_wire_display_driver_top #(
	parameter int DIGIT_COUNT = ssd_drv_pkg::DIGIT_COUNT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  ssd_drv_pkg::in_item_t                  in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output ssd_drv_pkg::out_item_t                 out_data,
	input  logic                                   cfg_we,
	input  logic [ssd_drv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssd_drv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int SYM_W = ssd_drv_pkg::SYM_W;
	localparam int PH_W  = ssd_drv_pkg::PH_W;

	// frame layout: start, 0x40, stop, start, 0xC0, digits, stop, start, ctrl, stop
	localparam logic [SYM_W-1:0] SYM_START0 = SYM_W'(0);
	localparam logic [SYM_W-1:0] SYM_CMD    = SYM_W'(1);
	localparam logic [SYM_W-1:0] SYM_STOP0  = SYM_W'(2);
	localparam logic [SYM_W-1:0] SYM_START1 = SYM_W'(3);
	localparam logic [SYM_W-1:0] SYM_ADDR   = SYM_W'(4);
	localparam logic [SYM_W-1:0] SYM_SEG0   = SYM_W'(5);
	localparam logic [SYM_W-1:0] SYM_STOP1  = SYM_W'(5 + DIGIT_COUNT);
	localparam logic [SYM_W-1:0] SYM_START2 = SYM_W'(6 + DIGIT_COUNT);
	localparam logic [SYM_W-1:0] SYM_STOP2  = SYM_W'(8 + DIGIT_COUNT);
	localparam logic [SYM_W-1:0] SYM_LAST   = SYM_W'(8 + DIGIT_COUNT);

	// config registers
	logic [2:0] brightness_q;
	logic       display_enable_q;

	// sequencer state
	logic             active_q;
	logic [SYM_W-1:0] sym_q;
	logic [PH_W-1:0]  phase_q;
	logic             clk_lvl_q;
	logic             dio_lvl_q;
	logic             dio_drv_q;

	// result register
	logic                   out_valid_q;
	ssd_drv_pkg::out_item_t out_data_q;

	// next-state values
	logic             active_d;
	logic [SYM_W-1:0] sym_d;
	logic [PH_W-1:0]  phase_d;
	logic             clk_lvl_d;
	logic             dio_lvl_d;
	logic             dio_drv_d;
	logic             done_d;

	logic                        in_accept;
	logic                        load_start;
	logic [DIGIT_COUNT-1:0][7:0] seg_codes;
	ssd_drv_pkg::elem_kind_t     kind;
	logic [PH_W-1:0]             elem_len;
	logic [7:0]                  byte_val;
	logic [8:0]                  phase_x11;
	logic [2:0]                  bit_idx;
	logic [PH_W-1:0]             bit_x3;
	logic [1:0]                  sub_ph;

	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;
	assign load_start = in_accept & (in_data.func == ssd_drv_pkg::FUNC_LOAD) & ~active_q;

	ssd_drv_conv #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (load_start),
		.number   (in_data.number),
		.seg_codes(seg_codes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q     <= ssd_drv_pkg::BRIGHTNESS_RST;
			display_enable_q <= ssd_drv_pkg::ENABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ssd_drv_pkg::CFG_BRIGHTNESS:     brightness_q     <= cfg_wdata;
				ssd_drv_pkg::CFG_DISPLAY_ENABLE: display_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// element kind and length at the current position
	always_comb begin
		kind = ssd_drv_pkg::ELEM_BYTE;
		if (sym_q == SYM_START0 || sym_q == SYM_START1 || sym_q == SYM_START2)
			kind = ssd_drv_pkg::ELEM_START;
		else if (sym_q == SYM_STOP0 || sym_q == SYM_STOP1 || sym_q == SYM_STOP2)
			kind = ssd_drv_pkg::ELEM_STOP;
	end

	always_comb begin
		case (kind)
			ssd_drv_pkg::ELEM_START: elem_len = ssd_drv_pkg::START_LEN;
			ssd_drv_pkg::ELEM_STOP:  elem_len = ssd_drv_pkg::STOP_LEN;
			default:                 elem_len = ssd_drv_pkg::BYTE_LEN;
		endcase
	end

	// byte being sent; the control byte follows the registers live
	always_comb begin
		byte_val = ssd_drv_pkg::CMD_CTRL_BASE | {4'b0, display_enable_q, brightness_q};
		if (sym_q == SYM_CMD)
			byte_val = ssd_drv_pkg::CMD_DATA;
		else if (sym_q == SYM_ADDR)
			byte_val = ssd_drv_pkg::CMD_ADDR;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (sym_q == SYM_SEG0 + SYM_W'(i))
				byte_val = seg_codes[i];
		end
	end

	// phase / 3 as (phase * 11) >> 5, exact for the 24 data phases
	assign phase_x11 = {phase_q, 3'b0} + {2'b0, phase_q, 1'b0} + {4'b0, phase_q};
	assign bit_idx   = phase_x11[7:5];
	assign bit_x3    = {1'b0, bit_idx, 1'b0} + {2'b0, bit_idx};
	assign sub_ph    = 2'(phase_q - bit_x3);

	// sequencer next state
	always_comb begin
		active_d  = active_q;
		sym_d     = sym_q;
		phase_d   = phase_q;
		clk_lvl_d = clk_lvl_q;
		dio_lvl_d = dio_lvl_q;
		dio_drv_d = dio_drv_q;
		done_d    = 1'b0;

		if (in_accept) begin
			if (in_data.func == ssd_drv_pkg::FUNC_LOAD) begin
				// a load while a frame runs is dropped
				if (!active_q) begin
					active_d = 1'b1;
					sym_d    = '0;
					phase_d  = '0;
				end
			end else if (active_q) begin
				case (kind)
					ssd_drv_pkg::ELEM_START: begin
						dio_drv_d = 1'b1;
						if (phase_q == PH_W'(0)) begin
							clk_lvl_d = 1'b1;
							dio_lvl_d = 1'b1;
						end else if (phase_q == PH_W'(1)) begin
							dio_lvl_d = 1'b0;
						end else begin
							clk_lvl_d = 1'b0;
						end
					end
					ssd_drv_pkg::ELEM_STOP: begin
						dio_drv_d = 1'b1;
						if (phase_q == PH_W'(0))
							clk_lvl_d = 1'b0;
						else if (phase_q == PH_W'(1))
							dio_lvl_d = 1'b0;
						else if (phase_q == PH_W'(2))
							clk_lvl_d = 1'b1;
						else
							dio_lvl_d = 1'b1;
					end
					default: begin
						if (phase_q < ssd_drv_pkg::PH_ACK_CLK_LOW) begin
							// LSB first: clock low, data, clock high
							dio_drv_d = 1'b1;
							if (sub_ph == 2'd0)
								clk_lvl_d = 1'b0;
							else if (sub_ph == 2'd1)
								dio_lvl_d = byte_val[bit_idx];
							else
								clk_lvl_d = 1'b1;
						end else if (phase_q == ssd_drv_pkg::PH_ACK_CLK_LOW) begin
							clk_lvl_d = 1'b0;
						end else if (phase_q == ssd_drv_pkg::PH_ACK_RELEASE) begin
							dio_drv_d = 1'b0;
						end else if (phase_q == ssd_drv_pkg::PH_ACK_CLK_HIGH) begin
							clk_lvl_d = 1'b1;
						end else begin
							clk_lvl_d = 1'b0;
						end
					end
				endcase

				if (phase_q == elem_len - 1'b1) begin
					phase_d = '0;
					if (sym_q == SYM_LAST) begin
						sym_d    = '0;
						active_d = 1'b0;
						done_d   = 1'b1;
					end else begin
						sym_d = sym_q + 1'b1;
					end
				end else begin
					phase_d = phase_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			sym_q     <= '0;
			phase_q   <= '0;
			clk_lvl_q <= 1'b1;
			dio_lvl_q <= 1'b1;
			dio_drv_q <= 1'b1;
		end else begin
			active_q  <= active_d;
			sym_q     <= sym_d;
			phase_q   <= phase_d;
			clk_lvl_q <= clk_lvl_d;
			dio_lvl_q <= dio_lvl_d;
			dio_drv_q <= dio_drv_d;
		end
	end

	// result register; a new request may enter as the held result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q.clock_line <= clk_lvl_d;
			// released line reads as the pull-up level
			out_data_q.data_line  <= dio_drv_d ? dio_lvl_d : 1'b1;
			out_data_q.data_drive <= dio_drv_d;
			out_data_q.busy_res   <= active_d;
			out_data_q.frame_done <= done_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> !out_data.busy_res)
		else $error("frame_done with busy_res set");

	a_release_pullup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.data_drive |-> out_data.data_line)
		else $error("released data line not at pull-up level");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> phase_q < elem_len)
		else $error("phase count past element length");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall)
		else $error("input stalled without a held result");
`endif

endmodule

// File: bench/seven_segment_two_wire_display_driver_top_tb.sv
`timescale 1ns / 1ps

module seven_segment_two_wire_display_driver_top_tb;
	// Bench for the two-wire seven-segment display driver.
	// A request is either a load (arms a frame with a new number) or a tick (one
	// wait period of the pin sequence). Every accepted request yields one result:
	// the pin levels after the step plus busy and frame-done flags. The bench
	// keeps its own copy of the frame sequencer, predicts each result when the
	// request is accepted and compares results in order as they come out.

	localparam int DIGITS       = ssd_drv_pkg::DIGIT_COUNT_DEF;
	localparam int SYMBOLS      = 9 + DIGITS;    // starts, bytes and stops of one update
	localparam int QUIET_LIMIT  = 3000;          // cycles with no transfer on either side
	localparam int HOLD_CYCLES  = 400;           // long receiver hold-off
	localparam int SETTLE       = 4;             // spare cycles before a register write
	localparam int RANDOM_ITEMS = 200;
	localparam int MAX_REPORTS  = 50;

	// seven-segment glyphs for digits 0..9, digit d at bits [8d +: 8]
	localparam logic [79:0] GLYPHS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
		8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	ssd_drv_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	ssd_drv_pkg::out_item_t out_data;
	logic cfg_we;
	logic [ssd_drv_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ssd_drv_pkg::CFG_DATA_W-1:0] cfg_wdata;

	seven_segment_two_wire_display_driver_top #(
		.DIGIT_COUNT(DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// Shadow of the frame sequencer
	// ------------------------------------------------------------------
	logic [3:0] fr_pos;                 // current start/byte/stop element
	logic [4:0] fr_phase;               // phase inside that element
	logic [7:0] fr_codes [DIGITS];      // segment bytes of the loaded number
	logic       fr_busy;
	logic       pin_clk, pin_dio, pin_drv;
	logic [2:0] reg_bright;
	logic       reg_enable;

	ssd_drv_pkg::out_item_t pending_pins [$];   // predicted results, oldest first

	// statistics and status
	int unsigned requests_sent, effective_requests, results_checked;
	int unsigned frames_done, loads_ignored, idle_ticks, reg_writes;
	int unsigned mismatches;

	// traffic shaping knobs, set by the test tasks
	logic idle_on;                      // random gaps on both sides
	logic hold_off_go;                  // receiver: one long hold-off requested

	function automatic ssd_drv_pkg::elem_kind_t elem_at(input logic [3:0] s);
		if (s == 0 || s == 3 || s == 6 + DIGITS)
			return ssd_drv_pkg::ELEM_START;
		if (s == 2 || s == 5 + DIGITS || s == 8 + DIGITS)
			return ssd_drv_pkg::ELEM_STOP;
		return ssd_drv_pkg::ELEM_BYTE;
	endfunction

	function automatic logic [4:0] elem_len(input ssd_drv_pkg::elem_kind_t k);
		if (k == ssd_drv_pkg::ELEM_START)
			return ssd_drv_pkg::START_LEN;
		if (k == ssd_drv_pkg::ELEM_STOP)
			return ssd_drv_pkg::STOP_LEN;
		return ssd_drv_pkg::BYTE_LEN;
	endfunction

	// byte sent by element s; the control byte reads the registers live
	function automatic logic [7:0] byte_at(input logic [3:0] s);
		if (s == 1)
			return ssd_drv_pkg::CMD_DATA;
		if (s == 4)
			return ssd_drv_pkg::CMD_ADDR;
		if (s >= 5 && s < 5 + DIGITS)
			return fr_codes[s - 5];
		return ssd_drv_pkg::CMD_CTRL_BASE | {4'b0000, reg_enable, reg_bright};
	endfunction

	task automatic reset_shadow();
		fr_pos = '0;
		fr_phase = '0;
		for (int i = 0; i < DIGITS; i++)
			fr_codes[i] = '0;
		fr_busy = 1'b0;
		pin_clk = 1'b1;
		pin_dio = 1'b1;
		pin_drv = 1'b1;
		reg_bright = ssd_drv_pkg::BRIGHTNESS_RST;
		reg_enable = ssd_drv_pkg::ENABLE_RST;
	endtask

	// advance the shadow by one accepted request and queue the pin levels it gives
	task automatic predict_pins(input logic f, input logic [15:0] num);
		logic [3:0] s;
		logic [4:0] p;
		logic done;
		logic [7:0] b;
		int unsigned modulus, n, bit_idx, sub;
		ssd_drv_pkg::out_item_t r;
		done = 1'b0;
		if (f == ssd_drv_pkg::FUNC_LOAD) begin
			if (!fr_busy) begin
				modulus = 1;
				for (int i = 0; i < DIGITS; i++)
					modulus = modulus * 10;
				n = num % modulus;
				for (int i = DIGITS - 1; i >= 0; i--) begin
					fr_codes[i] = GLYPHS[(n % 10) * 8 +: 8];
					n = n / 10;
				end
				fr_pos = '0;
				fr_phase = '0;
				fr_busy = 1'b1;
				effective_requests++;
			end else begin
				loads_ignored++;
			end
		end else if (fr_busy) begin
			s = fr_pos;
			p = fr_phase;
			effective_requests++;
			case (elem_at(s))
				ssd_drv_pkg::ELEM_START: begin
					pin_drv = 1'b1;
					if (p == 0) begin
						pin_clk = 1'b1;
						pin_dio = 1'b1;
					end else if (p == 1) begin
						pin_dio = 1'b0;
					end else begin
						pin_clk = 1'b0;
					end
				end
				ssd_drv_pkg::ELEM_STOP: begin
					pin_drv = 1'b1;
					if (p == 0)
						pin_clk = 1'b0;
					else if (p == 1)
						pin_dio = 1'b0;
					else if (p == 2)
						pin_clk = 1'b1;
					else
						pin_dio = 1'b1;
				end
				default: begin
					// eight data bits, three phases each, then the ack slot
					if (p < ssd_drv_pkg::PH_ACK_CLK_LOW) begin
						bit_idx = p / 3;
						sub = p % 3;
						pin_drv = 1'b1;
						if (sub == 0) begin
							pin_clk = 1'b0;
						end else if (sub == 1) begin
							b = byte_at(s);
							pin_dio = b[bit_idx];
						end else begin
							pin_clk = 1'b1;
						end
					end else if (p == ssd_drv_pkg::PH_ACK_CLK_LOW) begin
						pin_clk = 1'b0;
					end else if (p == ssd_drv_pkg::PH_ACK_RELEASE) begin
						pin_drv = 1'b0;
					end else if (p == ssd_drv_pkg::PH_ACK_CLK_HIGH) begin
						pin_clk = 1'b1;
					end else begin
						pin_clk = 1'b0;
					end
				end
			endcase
			p = p + 1;
			if (p >= elem_len(elem_at(s))) begin
				p = '0;
				s = s + 1;
				if (s >= SYMBOLS) begin
					s = '0;
					fr_busy = 1'b0;
					done = 1'b1;
					frames_done++;
				end
			end
			fr_pos = s;
			fr_phase = p;
		end else begin
			idle_ticks++;
		end
		r.clock_line = pin_clk;
		r.data_line  = pin_drv ? pin_dio : 1'b1;   // released line reads pull-up
		r.data_drive = pin_drv;
		r.busy_res   = fr_busy;
		r.frame_done = done;
		pending_pins.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	function automatic int unsigned pick_gap();
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 15);
		return $urandom_range(4, 1);
	endfunction

	// Offer one request, called at a rising edge. Valid stays high when no gap
	// follows, so back-to-back requests never lower and raise it in one step.
	task automatic issue_request(input logic f, input logic [15:0] num);
		in_valid <= 1'b1;
		in_data <= '{func: f, number: num};
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predict_pins(f, num);
		requests_sent++;
		if (idle_on && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	// sender pauses until every predicted result has been seen
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_pins.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input logic [ssd_drv_pkg::CFG_IDX_W-1:0] idx,
		input logic [ssd_drv_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == ssd_drv_pkg::CFG_BRIGHTNESS)
			reg_bright = val;
		else if (idx == ssd_drv_pkg::CFG_DISPLAY_ENABLE)
			reg_enable = val[0];
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One whole update: a load, then ticks until the frame finishes. A share of
	// the ticks is swapped for loads that arrive while busy and must be ignored.
	task automatic run_frame(input logic [15:0] num, input int unsigned noise_pct);
		issue_request(ssd_drv_pkg::FUNC_LOAD, num);
		while (fr_busy) begin
			if ($urandom_range(99) < noise_pct)
				issue_request(ssd_drv_pkg::FUNC_LOAD, 16'($urandom));
			else
				issue_request(ssd_drv_pkg::FUNC_TICK, 16'($urandom));
		end
	endtask

	function automatic logic [15:0] pick_number();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'd9999;
			2: return 16'd10000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Receiver side: random stalls plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin : receiver
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_go) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_go = 1'b0;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(99) < 30) begin
				out_stall <= 1'b1;
				repeat (pick_gap()) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	ssd_drv_pkg::out_item_t want_pins;

	function automatic void check_pin(input string name, input logic want_b,
		input logic got_b);
		if (want_b !== got_b) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %b, actual %b",
					$time, name, want_b, got_b);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_pins.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %b",
						$time, out_data);
			end else begin
				want_pins = pending_pins.pop_front();
				check_pin("clock_line", want_pins.clock_line, out_data.clock_line);
				check_pin("data_line",  want_pins.data_line,  out_data.data_line);
				check_pin("data_drive", want_pins.data_drive, out_data.data_drive);
				check_pin("busy_res",   want_pins.busy_res,   out_data.busy_res);
				check_pin("frame_done", want_pins.frame_done, out_data.frame_done);
			end
			results_checked++;
		end
	end

	// watchdog: too long without any transfer means the block hung
	int unsigned quiet_cycles;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, QUIET_LIMIT, pending_pins.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// ticks on an idle block change nothing; number bits are don't-care
	task automatic test_idle_ticks();
		issue_request(ssd_drv_pkg::FUNC_TICK, 16'h0000);
		issue_request(ssd_drv_pkg::FUNC_TICK, 16'hFFFF);
		issue_request(ssd_drv_pkg::FUNC_TICK, 16'($urandom));
	endtask

	// modulo wrap and the largest number, clean back-to-back ticks; the second
	// load comes straight after the last phase and arms anew
	task automatic test_number_extremes();
		run_frame(16'd10000, 0);
		run_frame(16'hFFFF, 0);
	endtask

	// loads while busy are dropped
	task automatic test_busy_loads();
		issue_request(ssd_drv_pkg::FUNC_LOAD, 16'd4321);
		issue_request(ssd_drv_pkg::FUNC_LOAD, 16'd8765);
		issue_request(ssd_drv_pkg::FUNC_LOAD, 16'hFFFF);
		while (fr_busy) begin
			if ($urandom_range(99) < 20)
				issue_request(ssd_drv_pkg::FUNC_LOAD, 16'($urandom));
			else
				issue_request(ssd_drv_pkg::FUNC_TICK, 16'($urandom));
		end
	endtask

	// control byte with both registers at zero, written only while quiet
	task automatic test_register_settings();
		idle_on = 1'b1;
		settle_idle();
		write_register(ssd_drv_pkg::CFG_BRIGHTNESS, 3'd0);
		write_register(ssd_drv_pkg::CFG_DISPLAY_ENABLE, 3'd0);
		run_frame(16'd9999, 5);
		settle_idle();
		write_register(ssd_drv_pkg::CFG_BRIGHTNESS, ssd_drv_pkg::BRIGHTNESS_RST);
		write_register(ssd_drv_pkg::CFG_DISPLAY_ENABLE, {2'b00, ssd_drv_pkg::ENABLE_RST});
	endtask

	// receiver holds off for a long stretch while the sender keeps offering,
	// so the result register fills and the input stalls
	task automatic test_backpressure();
		idle_on = 1'b0;
		settle_idle();
		hold_off_go = 1'b1;
		run_frame(pick_number(), 10);
		while (hold_off_go)
			@(posedge clk);
		idle_on = 1'b1;
	endtask

	// mostly well-formed frames with random content, some noise and idle ticks;
	// idling switches on and off per frame
	task automatic test_random_traffic();
		int unsigned first;
		first = effective_requests;
		while (effective_requests - first < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(3) != 0);
			settle_idle();
			write_register(ssd_drv_pkg::CFG_BRIGHTNESS, 3'($urandom_range(7)));
			write_register(ssd_drv_pkg::CFG_DISPLAY_ENABLE, 3'($urandom_range(1)));
			run_frame(pick_number(), $urandom_range(15));
			repeat ($urandom_range(3))
				issue_request(ssd_drv_pkg::FUNC_TICK, 16'($urandom));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		idle_on = 1'b0;
		hold_off_go = 1'b0;
		quiet_cycles = 0;
		requests_sent = 0;
		effective_requests = 0;
		results_checked = 0;
		frames_done = 0;
		loads_ignored = 0;
		idle_ticks = 0;
		reg_writes = 0;
		mismatches = 0;
		reset_shadow();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_number_extremes();
		idle_on = 1'b1;
		test_busy_loads();
		test_register_settings();
		test_backpressure();
		test_random_traffic();

		// drain, then let the result register show any strays
		settle_idle();
		repeat (8) @(posedge clk);

		$display("Sent %0d requests and checked %0d results: %0d frames, %0d ignored loads,",
			requests_sent, results_checked, frames_done, loads_ignored);
		$display("%0d idle ticks, %0d register writes, %0d field mismatches",
			idle_ticks, reg_writes, mismatches);
		if (mismatches == 0 && pending_pins.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
